/* rtl/gspc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspc_pkg
// shared types, codes and frame tables of the gamepad serial poll controller
// ----------------------------------------------------------------------------
package gspc_pkg;

  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_CONFIG = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_NO_CTRL  = 2'd2,
    ST_NOT_ANLG = 2'd3
  } status_e;

  localparam logic [2:0] REG_GAP     = 3'd0;
  localparam logic [2:0] REG_TPM     = 3'd1;
  localparam logic [2:0] REG_MAXERR  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_PWRUP   = 3'd4;

  localparam logic [7:0] MODE_DIG  = 8'h41;
  localparam logic [7:0] MODE_ANA  = 8'h73;
  localparam logic [7:0] MODE_ANP  = 8'h79;
  localparam logic [7:0] ACK_BYTE  = 8'h5A;
  localparam logic [3:0] MAX_DELAY = 4'd11;
  localparam logic [3:0] MAX_TRIES = 4'd10;

  typedef struct packed {
    logic [7:0]  gap_ticks;
    logic [15:0] ticks_per_ms;
    logic [7:0]  max_errors;
    logic [15:0] link_timeout_ms;
    logic [9:0]  power_up_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        dat_in;
  } in_t;

  typedef struct packed {
    logic        att_out;
    logic        clk_out;
    logic        cmd_out;
    logic        done_res;
    logic [1:0]  status;
    logic [7:0]  mode_byte;
    logic [15:0] buttons;
    logic [15:0] pressed_mask;
    logic [15:0] released_mask;
    logic [31:0] stick_bytes;
    logic [7:0]  error_count;
    logic        connected;
  } res_t;

  function automatic logic [7:0] frame_byte(input logic [1:0] kind, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (kind)
      2'd0: case (idx)
        4'd0: b = 8'h01; 4'd1: b = 8'h42; default: b = 8'h00;
      endcase
      2'd1: case (idx)
        4'd0: b = 8'h01; 4'd1: b = 8'h43; 4'd3: b = 8'h01; default: b = 8'h00;
      endcase
      2'd2: case (idx)
        4'd0: b = 8'h01; 4'd1: b = 8'h44; 4'd3: b = 8'h01; 4'd4: b = 8'h03;
        default: b = 8'h00;
      endcase
      default: case (idx)
        4'd0: b = 8'h01; 4'd1: b = 8'h43; 4'd2, 4'd3: b = 8'h00;
        default: b = 8'h5A;
      endcase
    endcase
    return b;
  endfunction

  function automatic logic [3:0] frame_len(input logic [1:0] kind);
    return (kind == 2'd1) ? 4'd5 : 4'd9;
  endfunction

  function automatic logic mode_valid(input logic [7:0] m);
    return (m == MODE_DIG) || (m == MODE_ANA) || (m == MODE_ANP);
  endfunction

endpackage

/* rtl/gspc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspc_in_if / gspc_res_if
// valid/ready channels for tick beats and result beats
// ----------------------------------------------------------------------------
interface gspc_in_if;
  logic           valid;
  logic           ready;
  gspc_pkg::in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gspc_res_if;
  logic           valid;
  logic           ready;
  gspc_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/gamepad_serial_poll_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_serial_poll_controller_unit
// host side of a game controller serial link, one protocol tick per beat
// ----------------------------------------------------------------------------
// Each input beat is one protocol tick carrying a command and the sampled data
// line; each accepted beat yields exactly one result beat with the line levels
// and status for that tick. One beat per clock is sustained while the result
// side keeps taking beats: the tick logic sits between the state registers and
// a two-entry output stage, so a new tick is taken while a previous result still
// waits downstream. A result beat is registered into the main output register,
// or into the skid register while the main one is held, and the input only
// stalls while both output entries are full. Configure via the apb port only while idle.
module gamepad_serial_poll_controller_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  gspc_in_if.sink           in_if,
  gspc_res_if.source        res_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  gspc_pkg::cfg_t cfg;
  gspc_pkg::res_t res;
  logic           step;

  gspc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // output stage: main register plus skid register
  gspc_pkg::res_t out_q, skid_q;
  logic           out_vld_q, skid_vld_q;

  // accept while the skid slot is free
  assign in_if.ready = !skid_vld_q;
  assign step        = in_if.valid && in_if.ready;

  gspc_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .step_i(step), .in_i(in_if.payload), .res_o(res)
  );

  assign res_if.valid   = out_vld_q;
  assign res_if.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || res_if.ready) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= step;
        end else begin
          out_vld_q <= step;
        end
      end else if (step) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || res_if.ready) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
        if (step) skid_q <= res;
      end else if (step) begin
        out_q <= res;
      end
    end else if (step) begin
      skid_q <= res;
    end
  end
endmodule

/* rtl/gspc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspc_cfg_regs
// apb register file holding the link timing and error limit configuration
// ----------------------------------------------------------------------------
module gspc_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output gspc_pkg::cfg_t   cfg_o
);
  gspc_pkg::cfg_t cfg_q;
  logic [2:0] idx;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_ticks       <= 8'd4;
      cfg_q.ticks_per_ms    <= 16'd200;
      cfg_q.max_errors      <= 8'd3;
      cfg_q.link_timeout_ms <= 16'd250;
      cfg_q.power_up_ms     <= 10'd100;
    end else if (psel && penable && pwrite) begin
      case (idx)
        gspc_pkg::REG_GAP:     cfg_q.gap_ticks       <= pwdata[7:0];
        gspc_pkg::REG_TPM:     cfg_q.ticks_per_ms    <= pwdata[15:0];
        gspc_pkg::REG_MAXERR:  cfg_q.max_errors      <= pwdata[7:0];
        gspc_pkg::REG_TIMEOUT: cfg_q.link_timeout_ms <= pwdata[15:0];
        gspc_pkg::REG_PWRUP:   cfg_q.power_up_ms     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gspc_pkg::REG_GAP:     prdata = {24'd0, cfg_q.gap_ticks};
      gspc_pkg::REG_TPM:     prdata = {16'd0, cfg_q.ticks_per_ms};
      gspc_pkg::REG_MAXERR:  prdata = {24'd0, cfg_q.max_errors};
      gspc_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_q.link_timeout_ms};
      gspc_pkg::REG_PWRUP:   prdata = {22'd0, cfg_q.power_up_ms};
      default:               prdata = 32'd0;
    endcase
  end
endmodule

/* rtl/gspc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspc_core
// per-tick protocol sequencer: one accepted tick updates all state
// ----------------------------------------------------------------------------
module gspc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gspc_pkg::cfg_t  cfg_i,
  input  logic            step_i,
  input  gspc_pkg::in_t   in_i,
  output gspc_pkg::res_t  res_o
);
  typedef enum logic [2:0] {
    PH_IDLE, PH_PWRUP, PH_BEGIN, PH_BIT, PH_BYTEGAP, PH_END, PH_CMDDELAY
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic [1:0]  sub_q, sub_d;
  logic [15:0] wait_q, wait_d;
  logic [9:0]  msl_q, msl_d;
  logic [7:0]  rx_q, rx_d;
  logic [7:0]  fb_q [9];
  logic [7:0]  fb_d [9];
  logic [7:0]  mode_q, mode_d, err_q, err_d;
  logic [15:0] btn_q, btn_d, prev_q, prev_d, msg_q, msg_d, mtc_q, mtc_d;
  logic [3:0]  dly_q, dly_d, att_q, att_d;
  logic [2:0]  seq_q, seq_d;
  logic        link_q, link_d, fpo_q, fpo_d, opc_q, opc_d;

  logic [7:0]  gap;
  logic [15:0] tpm;
  assign gap = (cfg_i.gap_ticks == 8'd0) ? 8'd1 : cfg_i.gap_ticks;
  assign tpm = (cfg_i.ticks_per_ms == 16'd0) ? 16'd1 : cfg_i.ticks_per_ms;

  always_comb begin
    logic        att, clk, cmdl, done, ok, bad, msdone, gostart;
    logic [1:0]  st, kind;
    logic [7:0]  m, nerr, tx;
    logic [15:0] chg, wdec;
    logic [3:0]  nb;
    phase_d = phase_q; byte_d = byte_q; bit_d = bit_q; sub_d = sub_q;
    wait_d = wait_q; msl_d = msl_q; rx_d = rx_q; fb_d = fb_q;
    mode_d = mode_q; err_d = err_q; btn_d = btn_q; prev_d = prev_q;
    msg_d = msg_q; mtc_d = mtc_q; dly_d = dly_q; att_d = att_q; seq_d = seq_q;
    link_d = link_q; fpo_d = fpo_q; opc_d = opc_q;
    att = 1'b1; clk = 1'b1; cmdl = 1'b1; done = 1'b0; st = gspc_pkg::ST_OK;
    ok = 1'b0; bad = 1'b0; msdone = 1'b0; gostart = 1'b0; m = fb_q[1];
    nerr = err_q; nb = byte_q; tx = 8'd0;

    if ({1'b0, mtc_q} + 17'd1 >= {1'b0, tpm}) begin
      mtc_d = 16'd0;
      if (msg_q != 16'hFFFF) msg_d = msg_q + 16'd1;
    end else begin
      mtc_d = mtc_q + 16'd1;
    end

    // idle start: resolved into the entry phase, then handled in the same tick
    if (phase_q == PH_IDLE && in_i.command == gspc_pkg::CMD_POLL) begin
      opc_d = 1'b0;
      prev_d = btn_q;
      phase_d = PH_BEGIN; wait_d = {8'd0, gap};
    end else if (phase_q == PH_IDLE && in_i.command == gspc_pkg::CMD_CONFIG) begin
      opc_d = 1'b1; seq_d = 3'd0; fpo_d = 1'b0;
      if (cfg_i.power_up_ms != 10'd0) begin
        phase_d = PH_PWRUP; msl_d = cfg_i.power_up_ms; wait_d = tpm;
      end else begin
        prev_d = btn_q;
        phase_d = PH_BEGIN; wait_d = {8'd0, gap};
      end
    end

    kind = !opc_d ? 2'd0 : (seq_d == 3'd2) ? 2'd1 : (seq_d == 3'd3) ? 2'd2 :
           (seq_d == 3'd4) ? 2'd3 : 2'd0;
    wdec = wait_d - 16'd1;

    case (phase_d)
      PH_PWRUP, PH_CMDDELAY: begin
        wdec = (wait_d != 16'd0) ? wait_d - 16'd1 : 16'd0;
        wait_d = wdec;
        if (wdec == 16'd0) begin
          if (msl_d <= 10'd1) msdone = 1'b1;
          else begin
            msl_d = msl_d - 10'd1; wait_d = tpm;
          end
        end
        if (msdone) begin
          if (phase_d == PH_CMDDELAY) seq_d = seq_d + 3'd1;
          gostart = 1'b1;
        end
      end
      PH_BEGIN: begin
        att = 1'b0;
        wait_d = wdec;
        if (wdec == 16'd0) begin
          phase_d = PH_BIT; byte_d = 4'd0; bit_d = 3'd0; sub_d = 2'd0; rx_d = 8'd0;
        end
      end
      PH_BIT: begin
        att = 1'b0;
        tx = gspc_pkg::frame_byte(kind, byte_d);
        cmdl = (byte_d < 4'd9) ? tx[bit_d] : 1'b1;
        if (sub_d == 2'd0) sub_d = 2'd1;
        else if (sub_d == 2'd1) begin
          clk = 1'b0; sub_d = 2'd2;
        end else begin
          if (in_i.dat_in) rx_d[bit_d] = 1'b1;
          sub_d = 2'd0;
          if (bit_d == 3'd7) begin
            if (kind == 2'd0 && byte_d < 4'd9) fb_d[byte_d] = rx_d;
            phase_d = PH_BYTEGAP; wait_d = {8'd0, gap};
          end else bit_d = bit_d + 3'd1;
        end
      end
      PH_BYTEGAP: begin
        att = 1'b0;
        wait_d = wdec;
        if (wdec == 16'd0) begin
          nb = byte_d + 4'd1; byte_d = nb;
          if (nb >= gspc_pkg::frame_len(kind)) begin
            phase_d = PH_END; wait_d = {8'd0, gap};
          end else begin
            phase_d = PH_BIT; bit_d = 3'd0; sub_d = 2'd0; rx_d = 8'd0;
          end
        end
      end
      PH_END: begin
        wait_d = wdec;
        if (wdec == 16'd0) begin
          if (kind != 2'd0) begin
            phase_d = PH_CMDDELAY;
            msl_d = {6'd0, (dly_d == 4'd0) ? 4'd1 : dly_d};
            wait_d = tpm;
          end else begin
            m = fb_d[1];
            bad = !gspc_pkg::mode_valid(m) || fb_d[2] != gspc_pkg::ACK_BYTE;
            ok = !bad;
            if (bad) begin
              nerr = (err_d != 8'hFF) ? err_d + 8'd1 : err_d;
              err_d = nerr;
              if (nerr >= cfg_i.max_errors) link_d = 1'b0;
            end else begin
              err_d = 8'd0; mode_d = m; btn_d = {fb_d[4], fb_d[3]};
              link_d = 1'b1; msg_d = 16'd0;
            end
            if (!opc_d) begin
              phase_d = PH_IDLE; done = 1'b1;
              st = ok ? gspc_pkg::ST_OK : gspc_pkg::ST_BAD;
            end else if (seq_d == 3'd0) begin
              fpo_d = ok; seq_d = 3'd1; gostart = 1'b1;
            end else if (seq_d == 3'd1) begin
              if (!fpo_d && !ok) begin
                link_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; st = gspc_pkg::ST_NO_CTRL;
              end else begin
                dly_d = 4'd1; att_d = 4'd0; seq_d = 3'd2; gostart = 1'b1;
              end
            end else begin
              if (ok && (mode_d == gspc_pkg::MODE_ANA || mode_d == gspc_pkg::MODE_ANP)) begin
                phase_d = PH_IDLE; done = 1'b1; st = gspc_pkg::ST_OK;
              end else if (att_d >= gspc_pkg::MAX_TRIES) begin
                link_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
                st = gspc_pkg::mode_valid(mode_d) ? gspc_pkg::ST_NOT_ANLG : gspc_pkg::ST_BAD;
              end else begin
                if (dly_d < gspc_pkg::MAX_DELAY) dly_d = dly_d + 4'd1;
                att_d = att_d + 4'd1; seq_d = 3'd2; gostart = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase

    // frame restart after a wait or a probe; new frame kind from updated step
    if (gostart) begin
      if (!opc_d || !(seq_d == 3'd2 || seq_d == 3'd3 || seq_d == 3'd4)) prev_d = btn_d;
      phase_d = PH_BEGIN; wait_d = {8'd0, gap};
    end

    chg = prev_d ^ btn_d;
    res_o.att_out       = att;
    res_o.clk_out       = clk;
    res_o.cmd_out       = cmdl;
    res_o.done_res      = done;
    res_o.status        = st;
    res_o.mode_byte     = mode_d;
    res_o.buttons       = btn_d;
    res_o.pressed_mask  = chg & ~btn_d;
    res_o.released_mask = chg & ~prev_d;
    res_o.stick_bytes   = {fb_d[8], fb_d[7], fb_d[6], fb_d[5]};
    res_o.error_count   = err_d;
    res_o.connected     = link_d && (msg_d < cfg_i.link_timeout_ms);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; byte_q <= '0; bit_q <= '0; sub_q <= '0; wait_q <= '0;
      msl_q <= '0; rx_q <= '0;
      for (int i = 0; i < 9; i++) fb_q[i] <= 8'hFF;
      mode_q <= '0; err_q <= '0; btn_q <= 16'hFFFF; prev_q <= 16'hFFFF;
      msg_q <= '0; mtc_q <= '0; dly_q <= 4'd1; att_q <= '0; seq_q <= '0;
      link_q <= 1'b0; fpo_q <= 1'b0; opc_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; byte_q <= byte_d; bit_q <= bit_d; sub_q <= sub_d;
      wait_q <= wait_d; msl_q <= msl_d; rx_q <= rx_d; fb_q <= fb_d;
      mode_q <= mode_d; err_q <= err_d; btn_q <= btn_d; prev_q <= prev_d;
      msg_q <= msg_d; mtc_q <= mtc_d; dly_q <= dly_d; att_q <= att_d; seq_q <= seq_d;
      link_q <= link_d; fpo_q <= fpo_d; opc_q <= opc_d;
    end
  end
endmodule
